// ===== hdl/mmsdec_pkg.sv =====
// Shared types, tag codes and a helper function for the MMS data element decoder.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package mmsdec_pkg;

	localparam logic [7:0] TAG_INT_85  = 8'h85;
	localparam logic [7:0] TAG_INT_86  = 8'h86;
	localparam logic [7:0] TAG_INT_02  = 8'h02;
	localparam logic [7:0] TAG_BOOL    = 8'h83;
	localparam logic [7:0] TAG_TIME_8C = 8'h8c;
	localparam logic [7:0] TAG_TIME_91 = 8'h91;

	localparam logic [3:0] LEN_SAT     = 4'd15;
	localparam logic [3:0] LEN_MAX     = 4'd8;
	localparam logic [3:0] ACC_LIM_91  = 4'd4;
	localparam logic [3:0] ACC_LIM     = 4'd6;
	localparam logic [9:0] MS_PER_SEC  = 10'd1000;

	typedef enum logic [2:0] {
		PH_TAG,
		PH_LEN_FIRST,
		PH_LEN_LONG,
		PH_VALUE,
		PH_DRAIN
	} phase_t;

	typedef enum logic [1:0] {
		KIND_INT,
		KIND_BOOL,
		KIND_TIME,
		KIND_UNKNOWN
	} kind_t;

	// Element parse state after the current word has been applied.
	typedef struct packed {
		phase_t      phase;
		logic [7:0]  tag;
		logic        overflow;
		logic        error;
		logic [3:0]  declared;
		logic [3:0]  seen;
		logic [7:0]  first;
		logic [47:0] acc;
	} elem_t;

	function automatic kind_t kind_of(input logic [7:0] tag);
		kind_t k;
		k = KIND_UNKNOWN;
		if (tag == TAG_INT_85 || tag == TAG_INT_86 || tag == TAG_INT_02)
			k = KIND_INT;
		else if (tag == TAG_BOOL)
			k = KIND_BOOL;
		else if (tag == TAG_TIME_8C || tag == TAG_TIME_91)
			k = KIND_TIME;
		return k;
	endfunction

endpackage

// ===== hdl/mms_data_element_decoder.sv =====
// Streaming BER (tag, length, value) decoder for MMS data elements, top level.
// Depends on mmsdec_pkg, mmsdec_parser and mmsdec_eval.
//
// One byte of an element is taken per word on the input channel; the word with
// last_byte set closes the element and produces exactly one result word (kind,
// valid_res, decoded_value), all other words produce none. The block takes one
// word every clock except during the stall below: a word sits in the input
// register while the parser updates the element state and the evaluator forms
// the result, which is loaded into the output register and held there when the
// closing byte leaves the input register.
// The only stall is a closing byte held in the input register while the output
// register still holds a result not yet taken; in_ready stays low until it is.
module mms_data_element_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        valid_res,
	output logic [1:0]  kind,
	output logic [47:0] decoded_value
);

	logic                 v_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;
	logic                 adv;
	mmsdec_pkg::elem_t    elem;
	logic                 ok;
	mmsdec_pkg::kind_t    kind_c;
	logic [47:0]          value_c;
	logic                 out_valid_q;
	logic                 valid_res_q;
	logic [1:0]           kind_q;
	logic [47:0]          value_q;

	assign adv      = v_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	mmsdec_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.nxt       (elem)
	);

	mmsdec_eval u_eval (
		.elem  (elem),
		.ok    (ok),
		.kind  (kind_c),
		.value (value_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			valid_res_q <= ok;
			kind_q      <= kind_c;
			value_q     <= value_c;
		end
	end

	assign out_valid     = out_valid_q;
	assign valid_res     = valid_res_q;
	assign kind          = kind_q;
	assign decoded_value = value_q;

	a_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> decoded_value == 48'd0)
		else $error("invalid result carries nonzero value");

	a_unknown_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == mmsdec_pkg::KIND_UNKNOWN |-> !valid_res)
		else $error("unknown tag reported valid");

	a_int_fits_32: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res && kind == mmsdec_pkg::KIND_INT
		|-> decoded_value[47:32] == 16'd0)
		else $error("integer result wider than 32 bits");

	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && last_s1 && out_valid && !out_ready |=> v_s1 && last_s1)
		else $error("closing byte dropped while result pending");

endmodule

// ===== hdl/mmsdec_parser.sv =====
// Tag/length/value parser: holds the per-element state and computes its update.
// Depends on mmsdec_pkg.
module mmsdec_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output mmsdec_pkg::elem_t   nxt
);

	mmsdec_pkg::phase_t phase_q;
	mmsdec_pkg::phase_t phase_d;
	logic [7:0]         tag_q;
	logic [2:0]         left_q;
	logic [2:0]         left_d;
	logic [3:0]         declared_q;
	logic               overflow_q;
	logic [3:0]         seen_q;
	logic [47:0]        acc_q;
	logic [7:0]         first_q;
	logic               error_q;
	logic [6:0]         cnt;
	logic [3:0]         lim;

	assign cnt = data_byte[6:0];
	assign lim = (tag_q == mmsdec_pkg::TAG_TIME_91) ? mmsdec_pkg::ACC_LIM_91
		: mmsdec_pkg::ACC_LIM;

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			mmsdec_pkg::PH_TAG: begin
				phase_d = mmsdec_pkg::PH_LEN_FIRST;
			end
			mmsdec_pkg::PH_LEN_FIRST: begin
				if (data_byte[7]) begin
					if (cnt == 7'd0 || cnt > 7'd8)
						phase_d = mmsdec_pkg::PH_DRAIN;
					else
						phase_d = mmsdec_pkg::PH_LEN_LONG;
				end else begin
					phase_d = mmsdec_pkg::PH_VALUE;
				end
			end
			mmsdec_pkg::PH_LEN_LONG: begin
				if (left_q == 3'd0)
					phase_d = mmsdec_pkg::PH_VALUE;
			end
			mmsdec_pkg::PH_VALUE: phase_d = mmsdec_pkg::PH_VALUE;
			mmsdec_pkg::PH_DRAIN: phase_d = mmsdec_pkg::PH_DRAIN;
			default:              phase_d = mmsdec_pkg::PH_DRAIN;
		endcase
	end

	// element fields
	always_comb begin
		nxt          = '0;
		nxt.tag      = tag_q;
		nxt.overflow = overflow_q;
		nxt.error    = error_q;
		nxt.declared = declared_q;
		nxt.seen     = seen_q;
		nxt.first    = first_q;
		nxt.acc      = acc_q;
		left_d       = left_q;
		unique case (phase_q)
			mmsdec_pkg::PH_TAG: begin
				nxt     = '0;
				nxt.tag = data_byte;
				left_d  = 3'd0;
			end
			mmsdec_pkg::PH_LEN_FIRST: begin
				if (data_byte[7]) begin
					if (cnt == 7'd0 || cnt > 7'd8) begin
						nxt.error = 1'b1;
					end else begin
						left_d       = 3'(cnt - 7'd1);
						nxt.declared = 4'd0;
					end
				end else if (data_byte > 8'(mmsdec_pkg::LEN_MAX)) begin
					nxt.declared = mmsdec_pkg::LEN_SAT;
					nxt.overflow = 1'b1;
				end else begin
					nxt.declared = data_byte[3:0];
				end
			end
			mmsdec_pkg::PH_LEN_LONG: begin
				// big-endian length: any nonzero high byte already means > 8
				if (!overflow_q) begin
					if (declared_q != 4'd0 || data_byte > 8'(mmsdec_pkg::LEN_MAX)) begin
						nxt.overflow = 1'b1;
						nxt.declared = mmsdec_pkg::LEN_SAT;
					end else begin
						nxt.declared = data_byte[3:0];
					end
				end
				if (left_q != 3'd0)
					left_d = left_q - 3'd1;
			end
			mmsdec_pkg::PH_VALUE: begin
				if (seen_q == 4'd0)
					nxt.first = data_byte;
				if (seen_q < lim)
					nxt.acc = {acc_q[39:0], data_byte};
				if (seen_q != 4'd15)
					nxt.seen = seen_q + 4'd1;
			end
			mmsdec_pkg::PH_DRAIN: begin
				nxt.error = error_q;
			end
			default: begin
				nxt.error = 1'b1;
			end
		endcase
		nxt.phase = phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= mmsdec_pkg::PH_TAG;
			tag_q      <= '0;
			left_q     <= '0;
			declared_q <= '0;
			overflow_q <= 1'b0;
			seen_q     <= '0;
			acc_q      <= '0;
			first_q    <= '0;
			error_q    <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				// element closed: back to waiting for a tag
				phase_q    <= mmsdec_pkg::PH_TAG;
				tag_q      <= '0;
				left_q     <= '0;
				declared_q <= '0;
				overflow_q <= 1'b0;
				seen_q     <= '0;
				acc_q      <= '0;
				first_q    <= '0;
				error_q    <= 1'b0;
			end else begin
				phase_q    <= nxt.phase;
				tag_q      <= nxt.tag;
				left_q     <= left_d;
				declared_q <= nxt.declared;
				overflow_q <= nxt.overflow;
				seen_q     <= nxt.seen;
				acc_q      <= nxt.acc;
				first_q    <= nxt.first;
				error_q    <= nxt.error;
			end
		end
	end

endmodule

// ===== hdl/mmsdec_eval.sv =====
// Result evaluation: kind, validity and value from the closed element state.
// Depends on mmsdec_pkg.
module mmsdec_eval (
	input  mmsdec_pkg::elem_t  elem,
	output logic               ok,
	output mmsdec_pkg::kind_t  kind,
	output logic [47:0]        value
);

	logic        frame_ok;
	logic        rule_ok;
	logic [47:0] raw;
	logic [41:0] ms;

	assign kind     = mmsdec_pkg::kind_of(elem.tag);
	assign frame_ok = (elem.phase == mmsdec_pkg::PH_VALUE) && !elem.error
		&& !elem.overflow && (elem.seen == elem.declared);
	// seconds field times 1000
	assign ms       = 42'(elem.acc[31:0]) * 42'(mmsdec_pkg::MS_PER_SEC);

	always_comb begin
		rule_ok = 1'b0;
		raw     = '0;
		case (kind)
			mmsdec_pkg::KIND_INT: begin
				rule_ok = elem.seen >= 4'd1 && elem.seen <= 4'd5
					&& !(elem.tag == mmsdec_pkg::TAG_INT_85 && elem.first[7])
					&& (elem.seen < 4'd5 || elem.first == 8'd0);
				raw     = {16'd0, elem.acc[31:0]};
			end
			mmsdec_pkg::KIND_BOOL: begin
				rule_ok = elem.seen == 4'd1;
				raw     = {47'd0, elem.first != 8'd0};
			end
			mmsdec_pkg::KIND_TIME: begin
				if (elem.tag == mmsdec_pkg::TAG_TIME_8C) begin
					rule_ok = elem.seen == 4'd6;
					raw     = elem.acc;
				end else begin
					rule_ok = elem.seen == 4'd8;
					raw     = {6'd0, ms};
				end
			end
			default: begin
				rule_ok = 1'b0;
				raw     = '0;
			end
		endcase
	end

	assign ok    = frame_ok && rule_ok;
	assign value = ok ? raw : 48'd0;

endmodule
